// ===== rtl/axis_angle_rotation_matrix_about_point_defines.svh =====
// Assertion macros used by the checker file.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ABOUT_POINT_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ABOUT_POINT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define AARM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off during reset.
`define AARM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, always checked.
`define AARM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/aarm_pkg.sv =====
// ----------------------------------------------------------------------------
// aarm_pkg
// Types, constants and fixed-point helpers of the pivot rotation block.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int CORDIC_STAGES = 30;
   localparam int CW = 34;                  // CORDIC datapath width

   localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
   localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
   localparam logic signed [31:0] INV_GAIN    = 32'sd652032874;

   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
      32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
      32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
      32'd262143,    32'd131071,    32'd65535,     32'd32767,
      32'd16383,     32'd8191,      32'd4095,      32'd2047,
      32'd1023,      32'd511,       32'd255,       32'd127,
      32'd63,        32'd31,        32'd15,        32'd8,
      32'd4,         32'd2,         32'd1,         32'd0
   };

   typedef logic [2:0][31:0] vec_type;
   typedef logic [2:0][2:0][31:0] mat_type;

   typedef struct packed {
      vec_type axis;
      vec_type pivot;
   } geom_type;

   // round(a*b / 2^30), ties away from zero
   function automatic logic signed [41:0] mul_q30(input logic signed [35:0] a,
                                                  input logic signed [35:0] b);
      logic signed [71:0] p;
      logic [71:0] mag;
      logic [41:0] r;
      p = a * b;
      mag = p[71] ? 72'(-p) : 72'(p);
      r = 42'(mag >> 30) + 42'(mag[29]);
      return p[71] ? -signed'(r) : signed'(r);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647)
         return 32'sh7fffffff;
      else if (v < -48'sd2147483648)
         return 32'sh80000000;
      else
         return 32'(v);
   endfunction

endpackage

// ===== rtl/aarm_if.sv =====
// ----------------------------------------------------------------------------
// aarm_req_if / aarm_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface aarm_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] axis_x;
   logic signed [31:0] axis_y;
   logic signed [31:0] axis_z;
   logic signed [31:0] rot_angle;
   logic signed [31:0] pivot_x;
   logic signed [31:0] pivot_y;
   logic signed [31:0] pivot_z;
   modport source (output valid, axis_x, axis_y, axis_z, rot_angle,
                   pivot_x, pivot_y, pivot_z, input ready);
   modport sink   (input valid, axis_x, axis_y, axis_z, rot_angle,
                   pivot_x, pivot_y, pivot_z, output ready);
endinterface

interface aarm_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] r00, r01, r02, shift_x;
   logic signed [31:0] r10, r11, r12, shift_y;
   logic signed [31:0] r20, r21, r22, shift_z;
   modport source (output valid, r00, r01, r02, shift_x, r10, r11, r12, shift_y,
                   r20, r21, r22, shift_z, input ready);
   modport sink   (input valid, r00, r01, r02, shift_x, r10, r11, r12, shift_y,
                   r20, r21, r22, shift_z, output ready);
endinterface

// ===== rtl/axis_angle_rotation_matrix_about_point.sv =====
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_about_point
// Rotation about a pivot: CORDIC sine/cosine, Rodrigues matrix, p - R*p.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake      Payload
// req_chan   in   valid/ready    axis_x..z, rot_angle, pivot_x..z
// rsp_chan   out  valid/ready    r00..r22, shift_x..z
//
// One item per cycle while no result waits untaken; registers in order: fold,
// CORDIC stages, clamp, three matrix stages, two translation stages.
// The whole pipeline advances together; it holds while a result waits untaken.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_about_point import aarm_pkg::*; (
   input logic        clock,
   input logic        reset,
   aarm_req_if.sink   req_chan,
   aarm_rsp_if.source rsp_chan
);

   logic     en;
   logic     cv, rv, tv;
   logic signed [31:0] s, c;
   geom_type g_in, g;
   mat_type  rm, om;
   vec_type  rp, os;

   // advance when the result register is empty or being drained
   assign en = !tv || rsp_chan.ready;
   assign req_chan.ready = en;

   assign g_in.axis  = {req_chan.axis_z, req_chan.axis_y, req_chan.axis_x};
   assign g_in.pivot = {req_chan.pivot_z, req_chan.pivot_y, req_chan.pivot_x};

   aarm_cordic u_cordic (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_chan.valid), .in_angle(req_chan.rot_angle), .in_geom(g_in),
      .out_valid(cv), .out_sin(s), .out_cos(c), .out_geom(g)
   );

   aarm_rodrigues u_rodrigues (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(cv), .in_sin(s), .in_cos(c), .in_geom(g),
      .out_valid(rv), .out_mat(rm), .out_pivot(rp)
   );

   aarm_translate u_translate (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(rv), .in_mat(rm), .in_pivot(rp),
      .out_valid(tv), .out_mat(om), .out_shift(os)
   );

   assign rsp_chan.valid   = tv;
   assign rsp_chan.r00     = om[0][0];
   assign rsp_chan.r01     = om[0][1];
   assign rsp_chan.r02     = om[0][2];
   assign rsp_chan.shift_x = os[0];
   assign rsp_chan.r10     = om[1][0];
   assign rsp_chan.r11     = om[1][1];
   assign rsp_chan.r12     = om[1][2];
   assign rsp_chan.shift_y = os[1];
   assign rsp_chan.r20     = om[2][0];
   assign rsp_chan.r21     = om[2][1];
   assign rsp_chan.r22     = om[2][2];
   assign rsp_chan.shift_z = os[2];

endmodule

// ===== rtl/aarm_cordic.sv =====
// ----------------------------------------------------------------------------
// aarm_cordic
// Angle fold, unrolled rotation-mode CORDIC and sine/cosine clamp.
// ----------------------------------------------------------------------------
module aarm_cordic import aarm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] in_angle,
   input  geom_type           in_geom,
   output logic               out_valid,
   output logic signed [31:0] out_sin,
   output logic signed [31:0] out_cos,
   output geom_type           out_geom
);

   localparam int N = CORDIC_STAGES;

   logic signed [CW-1:0] x_ff [0:N];
   logic signed [CW-1:0] y_ff [0:N];
   logic signed [CW-1:0] z_ff [0:N];
   logic                 v_ff [0:N];
   logic                 flip_ff [0:N];
   geom_type             g_ff [0:N];

   logic signed [31:0] ang_c;
   logic signed [32:0] ang_f;
   logic               flip_in;

   logic               vo_ff;
   logic signed [31:0] so_ff, co_ff;
   geom_type           go_ff;
   logic signed [31:0] sc_in, cc_in;

   function automatic logic signed [31:0] clamp_one(input logic signed [CW-1:0] v);
      if (v > CW'(ONE_Q30))
         return ONE_Q30;
      else if (v < -CW'(ONE_Q30))
         return -ONE_Q30;
      else
         return 32'(v);
   endfunction

   // clamp to +-pi, fold into +-pi/2
   always_comb begin
      ang_c = in_angle;
      if (in_angle > PI_Q29)
         ang_c = PI_Q29;
      else if (in_angle < -PI_Q29)
         ang_c = -PI_Q29;
      flip_in = 1'b0;
      ang_f = 33'(ang_c);
      if (ang_c > HALF_PI_Q29) begin
         ang_f = 33'(ang_c) - 33'(PI_Q29);
         flip_in = 1'b1;
      end else if (ang_c < -HALF_PI_Q29) begin
         ang_f = 33'(ang_c) + 33'(PI_Q29);
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff[0] <= 1'b0;
      else if (en)
         v_ff[0] <= in_valid;
      if (en) begin
         x_ff[0]    <= CW'(INV_GAIN);
         y_ff[0]    <= '0;
         z_ff[0]    <= {ang_f, 1'b0};
         flip_ff[0] <= flip_in;
         g_ff[0]    <= in_geom;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [CW-1:0] dx, dy, da;
      logic signed [CW-1:0] x_in, y_in, z_in;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         da = CW'(ATAN_TAB[i]);
         if (!z_ff[i][CW-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - da;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + da;
         end
      end
      always_ff @(posedge clock) begin
         if (reset)
            v_ff[i+1] <= 1'b0;
         else if (en)
            v_ff[i+1] <= v_ff[i];
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
            g_ff[i+1]    <= g_ff[i];
         end
      end
   end

   always_comb begin
      cc_in = clamp_one(x_ff[N]);
      sc_in = clamp_one(y_ff[N]);
      if (flip_ff[N]) begin
         cc_in = -cc_in;
         sc_in = -sc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         vo_ff <= 1'b0;
      else if (en)
         vo_ff <= v_ff[N];
      if (en) begin
         so_ff <= sc_in;
         co_ff <= cc_in;
         go_ff <= g_ff[N];
      end
   end

   assign out_valid = vo_ff;
   assign out_sin   = so_ff;
   assign out_cos   = co_ff;
   assign out_geom  = go_ff;

endmodule

// ===== rtl/aarm_rodrigues.sv =====
// ----------------------------------------------------------------------------
// aarm_rodrigues
// Three-stage product pipeline forming the saturated rotation matrix.
// ----------------------------------------------------------------------------
module aarm_rodrigues import aarm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] in_sin,
   input  logic signed [31:0] in_cos,
   input  geom_type           in_geom,
   output logic               out_valid,
   output mat_type            out_mat,
   output vec_type            out_pivot
);

   // stage 1: squares, cross products, axis times sine
   logic               v1_ff;
   logic signed [33:0] sq1_ff [3];
   logic signed [33:0] cr1_ff [3];   // xy, xz, yz
   logic signed [33:0] as1_ff [3];
   logic signed [32:0] omc1_ff;
   logic signed [31:0] c1_ff;
   vec_type            p1_ff;

   // stage 2: scale by (1-c) and c
   logic               v2_ff;
   logic signed [35:0] cro2_ff [3];
   logic signed [35:0] dg2_ff [3];
   logic signed [33:0] sq2_ff [3];
   logic signed [33:0] as2_ff [3];
   vec_type            p2_ff;

   // stage 3: sums and saturation
   logic               v3_ff;
   mat_type            m3_ff;
   vec_type            p3_ff;
   mat_type            m_in;

   logic signed [31:0] ax [3];
   always_comb begin
      for (int k = 0; k < 3; k++)
         ax[k] = signed'(in_geom.axis[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq1_ff[k] <= 34'(mul_q30(36'(ax[k]), 36'(ax[k])));
            as1_ff[k] <= 34'(mul_q30(36'(ax[k]), 36'(in_sin)));
         end
         cr1_ff[0] <= 34'(mul_q30(36'(ax[0]), 36'(ax[1])));
         cr1_ff[1] <= 34'(mul_q30(36'(ax[0]), 36'(ax[2])));
         cr1_ff[2] <= 34'(mul_q30(36'(ax[1]), 36'(ax[2])));
         omc1_ff   <= 33'(ONE_Q30) - 33'(in_cos);
         c1_ff     <= in_cos;
         p1_ff     <= in_geom.pivot;

         for (int k = 0; k < 3; k++) begin
            cro2_ff[k] <= 36'(mul_q30(36'(cr1_ff[k]), 36'(omc1_ff)));
            dg2_ff[k]  <= 36'(mul_q30(36'(ONE_Q30) - 36'(sq1_ff[k]), 36'(c1_ff)));
            sq2_ff[k]  <= sq1_ff[k];
            as2_ff[k]  <= as1_ff[k];
         end
         p2_ff <= p1_ff;

         m3_ff <= m_in;
         p3_ff <= p2_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++)
         m_in[k][k] = sat32(48'(sq2_ff[k]) + 48'(dg2_ff[k]));
      m_in[0][1] = sat32(48'(cro2_ff[0]) - 48'(as2_ff[2]));
      m_in[0][2] = sat32(48'(cro2_ff[1]) + 48'(as2_ff[1]));
      m_in[1][0] = sat32(48'(cro2_ff[0]) + 48'(as2_ff[2]));
      m_in[1][2] = sat32(48'(cro2_ff[2]) - 48'(as2_ff[0]));
      m_in[2][0] = sat32(48'(cro2_ff[1]) - 48'(as2_ff[1]));
      m_in[2][1] = sat32(48'(cro2_ff[2]) + 48'(as2_ff[0]));
   end

   assign out_valid = v3_ff;
   assign out_mat   = m3_ff;
   assign out_pivot = p3_ff;

endmodule

// ===== rtl/aarm_translate.sv =====
// ----------------------------------------------------------------------------
// aarm_translate
// Translation column p - R*p, saturated, and the result register.
// ----------------------------------------------------------------------------
module aarm_translate import aarm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  mat_type in_mat,
   input  vec_type in_pivot,
   output logic    out_valid,
   output mat_type out_mat,
   output vec_type out_shift
);

   logic               v1_ff;
   logic signed [33:0] pr1_ff [3][3];
   mat_type            m1_ff;
   vec_type            p1_ff;

   logic               v2_ff;
   mat_type            m2_ff;
   vec_type            t2_ff;
   vec_type            t_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               pr1_ff[r][k] <= 34'(mul_q30(36'(signed'(in_mat[r][k])),
                                           36'(signed'(in_pivot[k]))));
         m1_ff <= in_mat;
         p1_ff <= in_pivot;
         m2_ff <= m1_ff;
         t2_ff <= t_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         t_in[r] = sat32(48'(signed'(p1_ff[r])) - 48'(pr1_ff[r][0])
                         - 48'(pr1_ff[r][1]) - 48'(pr1_ff[r][2]));
   end

   assign out_valid = v2_ff;
   assign out_mat   = m2_ff;
   assign out_shift = t2_ff;

endmodule

// ===== rtl/aarm_checker.sv =====
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks of the pivot rotation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "axis_angle_rotation_matrix_about_point_defines.svh"

module aarm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_r00,
   input logic [31:0] rsp_shift_z
);

   logic rsp_stall;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a waiting result stays offered
   `AARM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   // a waiting result keeps r00 and shift_z
   `AARM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall,
                     $stable(rsp_r00) && $stable(rsp_shift_z))
   // a stalled output freezes the pipeline, so no item enters
   `AARM_ASSERT_NOW(a_backpress, clock, reset, rsp_stall, !req_ready)
   // nothing comes out right after reset
   `AARM_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind axis_angle_rotation_matrix_about_point aarm_checker u_aarm_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_r00(rsp_chan.r00),
   .rsp_shift_z(rsp_chan.shift_z)
);
